/* rtl/core/stps_pkg.sv */
// ----------------------------------------------------------------------------
// Segment tree prefix sum package
// Shared sizes, item codes and the memory request type of the tree block.
// ----------------------------------------------------------------------------
package stps_pkg;

   localparam int LEVELS     = 10;
   localparam int LEAF_COUNT = 1 << LEVELS;
   localparam int NODE_COUNT = 1 << (LEVELS + 1);
   localparam int NODE_W     = LEVELS + 1;
   localparam int DATA_W     = 32;
   localparam int LEAF_W     = 10;
   localparam int BOUND_W    = 11;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [NODE_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } mem_req_type;

endpackage

/* rtl/core/stps_if.sv */
// ----------------------------------------------------------------------------
// Segment tree prefix sum channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface stps_req_if import stps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [LEAF_W-1:0]         leaf_index;
   logic signed [DATA_W-1:0]  add_value;
   logic [BOUND_W-1:0]        query_bound;

   modport source (output valid, kind, leaf_index, add_value, query_bound, input ready);
   modport sink (input valid, kind, leaf_index, add_value, query_bound, output ready);
endinterface

interface stps_rsp_if import stps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  prefix_sum;

   modport source (output valid, prefix_sum, input ready);
   modport sink (input valid, prefix_sum, output ready);
endinterface

/* rtl/core/segment_tree_prefix_sum.sv */
// Add beat: one read and one write per node, from the leaf up to the root.
// Query beat: climbs toward the root, then reads and sums each covering node on the single memory port,
// and then loads the response register; a zero bound goes straight to loading the response register.
// Reset is synchronous; afterwards a clearing pass zeroes all 2^(LEVELS+1) nodes,
// one per cycle, and no request beat is taken until it ends.
// ----------------------------------------------------------------------------
// Segment tree prefix sum
// Point-update, prefix-sum segment tree over 2^LEVELS signed 32-bit leaves.
// ----------------------------------------------------------------------------
module segment_tree_prefix_sum import stps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   stps_req_if.sink    req_bus,
   stps_rsp_if.source  rsp_bus
);

   mem_req_type       mem_req;
   logic [DATA_W-1:0] rd_data;
   logic              mem_busy;

   stps_node_mem u_node_mem (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (mem_req),
      .rd_data  (rd_data),
      .mem_busy (mem_busy)
   );

   stps_walk_seq u_walk_seq (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .mem_req  (mem_req),
      .rd_data  (rd_data),
      .mem_busy (mem_busy)
   );

endmodule

/* rtl/core/stps_node_mem.sv */
// ----------------------------------------------------------------------------
// Segment tree node memory
// Single-port node sum store with registered read data and a clearing pass
// that zeroes every node after reset.
// ----------------------------------------------------------------------------
module stps_node_mem import stps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  mem_req_type       mem_req,
   output logic [DATA_W-1:0] rd_data,
   output logic              mem_busy
);

   logic [DATA_W-1:0] node_sum_ff [NODE_COUNT];
   logic [DATA_W-1:0] rd_data_ff;
   logic [NODE_W-1:0] clr_addr_ff, clr_addr_in;
   logic              clearing_ff, clearing_in;
   logic              wr_en;
   logic [NODE_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + NODE_W'(1);
         if (&clr_addr_ff) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clearing_ff <= clearing_in;
      end
   end

   assign wr_en   = clearing_ff | mem_req.wr_en;
   assign wr_addr = clearing_ff ? clr_addr_ff : mem_req.addr;
   assign wr_data = clearing_ff ? '0 : mem_req.wdata;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_sum_ff[wr_addr] <= wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= node_sum_ff[mem_req.addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign mem_busy = clearing_ff;

endmodule

/* rtl/core/stps_walk_seq.sv */
// ----------------------------------------------------------------------------
// Segment tree walk sequencer
// Steps through the tree one node at a time for add and query beats, with
// one shared adder for node updates and prefix accumulation.
// ----------------------------------------------------------------------------
module stps_walk_seq import stps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   stps_req_if.sink          req_bus,
   stps_rsp_if.source        rsp_bus,
   output mem_req_type       mem_req,
   input  logic [DATA_W-1:0] rd_data,
   input  logic              mem_busy
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_QWALK  = 6'b000010,
      ST_QACC   = 6'b000100,
      ST_AREAD  = 6'b001000,
      ST_AWRITE = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   localparam logic [NODE_W-1:0] ROOT_SIZE = NODE_W'(LEAF_COUNT);
   localparam logic [NODE_W-1:0] NODE_ONE  = NODE_W'(1);

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] n_ff, n_in;
   logic [NODE_W-1:0] end_ff, end_in;
   logic [NODE_W-1:0] size_ff, size_in;
   logic [NODE_W-1:0] bound_ff, bound_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [NODE_W-1:0] sat_bound;
   logic [NODE_W-1:0] parent_end;
   logic              climb;
   logic [DATA_W-1:0] adder_b;
   logic [DATA_W-1:0] adder_sum;
   logic              req_fire;

   assign req_bus.ready = (state_ff == ST_IDLE) && !mem_busy;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign sat_bound = (32'(req_bus.query_bound) > 32'(LEAF_COUNT)) ? ROOT_SIZE
                                                                   : NODE_W'(req_bus.query_bound);

   assign parent_end = n_ff[0] ? end_ff : end_ff + size_ff;
   assign climb      = (size_ff != ROOT_SIZE) && (parent_end <= bound_ff);

   assign adder_b   = (state_ff == ST_AWRITE) ? val_ff : sum_ff;
   assign adder_sum = rd_data + adder_b;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      end_in       = end_ff;
      size_in      = size_ff;
      bound_in     = bound_ff;
      sum_in       = sum_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;
      mem_req.addr = n_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.kind == KIND_QUERY) begin
                  sum_in   = '0;
                  bound_in = sat_bound;
                  n_in     = ROOT_SIZE + sat_bound - NODE_ONE;
                  end_in   = sat_bound;
                  size_in  = NODE_ONE;
                  state_in = (sat_bound == '0) ? ST_DONE : ST_QWALK;
               end else begin
                  n_in     = ROOT_SIZE | NODE_W'(LEVELS'(req_bus.leaf_index));
                  val_in   = req_bus.add_value;
                  state_in = ST_AREAD;
               end
            end
         end
         ST_QWALK: begin
            if (climb) begin
               n_in    = n_ff >> 1;
               end_in  = parent_end;
               size_in = size_ff << 1;
            end else begin
               mem_req.rd_en = 1'b1;
               state_in      = ST_QACC;
            end
         end
         ST_QACC: begin
            sum_in = adder_sum;
            if (end_ff == size_ff) begin
               state_in = ST_DONE;
            end else begin
               n_in     = n_ff - NODE_ONE;
               end_in   = end_ff - size_ff;
               state_in = ST_QWALK;
            end
         end
         ST_AREAD: begin
            mem_req.rd_en = 1'b1;
            state_in      = ST_AWRITE;
         end
         ST_AWRITE: begin
            mem_req.wr_en = 1'b1;
            mem_req.wdata = adder_sum;
            n_in          = n_ff >> 1;
            state_in      = (n_ff == NODE_ONE) ? ST_IDLE : ST_AREAD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sum_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      end_ff      <= end_in;
      size_ff     <= size_in;
      bound_ff    <= bound_in;
      sum_ff      <= sum_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.prefix_sum = rsp_data_ff;

`ifndef SYNTHESIS
   a_add_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.kind == KIND_ADD) |=> (state_ff == ST_AREAD))
      else $error("Add beat did not start the leaf-to-root update.");

   a_walk_in_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QWALK) |-> ((end_ff != '0) && (end_ff <= bound_ff) && $onehot(size_ff)))
      else $error("Query walk left the covered prefix.");

   a_no_write_while_clearing: assert property (@(posedge clock) disable iff (reset)
      mem_busy |-> (!mem_req.wr_en && !req_bus.ready))
      else $error("Tree access during the clearing pass.");

   a_done_after_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AWRITE && n_ff == NODE_ONE) |=> (state_ff == ST_IDLE))
      else $error("Add walk did not stop after the root.");
`endif

endmodule

/* tb/sv/tb_segment_tree_prefix_sum.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment tree prefix sum testbench
// Sends add and query beats to the tree and keeps a flat copy of the leaf
// values. Each query is checked against the wrapped sum of the leaves below
// its bound. Both channels stall at random in the first two phases, and the
// last phase runs at full rate.
// ----------------------------------------------------------------------------
module tb_segment_tree_prefix_sum;
   import stps_pkg::*;

   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_ITEMS  = 195;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic                kind;
      logic [LEAF_W-1:0]   leaf;
      logic [DATA_W-1:0]   value;
      logic [BOUND_W-1:0]  bound;
   } tree_item_type;

   logic clock = 1'b0;
   logic reset;

   stps_req_if req_bus ();
   stps_rsp_if rsp_bus ();

   segment_tree_prefix_sum i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tree_item_type      pending_items[$];
   logic [DATA_W-1:0]  expected_sums[$];
   logic [DATA_W-1:0]  leaf_sums[LEAF_COUNT];

   int   items_queued   = 0;
   int   items_accepted = 0;
   int   fail_count     = 0;
   int   stall_cycles   = 0;
   int   req_gap_pct    = 0;
   int   rsp_stall_pct  = 0;
   logic req_beat_taken = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [DATA_W-1:0] prefix_below(logic [BOUND_W-1:0] bound);
      int unsigned        top;
      logic [DATA_W-1:0]  acc;
      top = (bound > LEAF_COUNT) ? LEAF_COUNT : bound;
      acc = '0;
      for (int i = 0; i < top; i++) acc += leaf_sums[i];
      return acc;
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return DATA_W'($urandom_range(16)) - DATA_W'(8);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [BOUND_W-1:0] pick_bound();
      int unsigned p;
      case ($urandom_range(7))
         0: return '0;
         1: return BOUND_W'(LEAF_COUNT);
         2: return BOUND_W'($urandom_range(2047, LEAF_COUNT + 1));
         3: begin
            p = 1 << $urandom_range(LEVELS);
            return BOUND_W'(p + $urandom_range(2) - 1);
         end
         default: return BOUND_W'($urandom_range(LEAF_COUNT, 1));
      endcase
   endfunction

   function automatic logic [LEAF_W-1:0] pick_leaf();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return LEAF_W'($urandom_range(7));
         default: return LEAF_W'($urandom_range(LEAF_COUNT - 1));
      endcase
   endfunction

   task automatic add_item(logic [LEAF_W-1:0] leaf, logic [DATA_W-1:0] value);
      tree_item_type it;
      it.kind  = KIND_ADD;
      it.leaf  = leaf;
      it.value = value;
      it.bound = BOUND_W'($urandom());
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic query_item(logic [BOUND_W-1:0] bound);
      tree_item_type it;
      it.kind  = KIND_QUERY;
      it.leaf  = LEAF_W'($urandom());
      it.value = $urandom();
      it.bound = bound;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic queue_random_items(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 55) add_item(pick_leaf(), pick_value());
         else query_item(pick_bound());
      end
   endtask

   task automatic wait_idle();
      while (items_accepted != items_queued || expected_sums.size() != 0)
         @(negedge clock);
   endtask

   always @(negedge clock) begin : drive_beats
      tree_item_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         if (!req_bus.valid || req_beat_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               it = pending_items.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.kind        <= it.kind;
               req_bus.leaf_index  <= it.leaf;
               req_bus.add_value   <= it.value;
               req_bus.query_bound <= it.bound;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_beats
      logic [DATA_W-1:0] want;
      req_beat_taken <= req_bus.valid && req_bus.ready;
      if (!reset) begin
         stall_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            stall_cycles = 0;
            items_accepted++;
            if (req_bus.kind == KIND_ADD)
               leaf_sums[req_bus.leaf_index] += req_bus.add_value;
            else
               expected_sums.push_back(prefix_below(req_bus.query_bound));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            stall_cycles = 0;
            if (expected_sums.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("Unexpected response beat: prefix_sum %h", rsp_bus.prefix_sum);
            end else begin
               want = expected_sums.pop_front();
               if (rsp_bus.prefix_sum !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("Prefix sum mismatch: expected %h, got %h",
                              want, rsp_bus.prefix_sum);
               end
            end
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin : stimulus
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.kind         = KIND_ADD;
      req_bus.leaf_index   = '0;
      req_bus.add_value    = '0;
      req_bus.query_bound  = '0;
      rsp_bus.ready        = 1'b0;
      for (int i = 0; i < LEAF_COUNT; i++) leaf_sums[i] = '0;

      req_gap_pct   = 23;
      rsp_stall_pct = 86;
      query_item('0);
      query_item(BOUND_W'(LEAF_COUNT));
      add_item('0, 32'h7fff_ffff);
      add_item('1, 32'h8000_0000);
      add_item('0, 32'h0000_0001);
      add_item(LEAF_W'(512), 32'hffff_ffff);
      add_item(LEAF_W'(341), 32'h5555_5555);
      add_item(LEAF_W'(682), 32'haaaa_aaaa);
      query_item('0);
      query_item(BOUND_W'(1));
      query_item(BOUND_W'(2));
      query_item(BOUND_W'(342));
      query_item(BOUND_W'(512));
      query_item(BOUND_W'(513));
      query_item(BOUND_W'(683));
      query_item(BOUND_W'(1023));
      query_item(BOUND_W'(LEAF_COUNT));
      query_item(BOUND_W'(LEAF_COUNT + 1));
      query_item('1);
      add_item('1, 32'h8000_0000);
      query_item('1);
      queue_random_items(PHASE_ITEMS);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait_idle();

      req_gap_pct   = 86;
      rsp_stall_pct = 23;
      queue_random_items(PHASE_ITEMS);
      wait_idle();

      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      queue_random_items(PHASE_ITEMS);
      wait_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_sums.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/stps_pkg.sv
rtl/core/stps_if.sv
rtl/core/stps_node_mem.sv
rtl/core/stps_walk_seq.sv
rtl/core/segment_tree_prefix_sum.sv
tb/sv/tb_segment_tree_prefix_sum.sv
